FILE: hdl/move_line_aim_and_advance_top_assert.svh
// ----------------------------------------------------------------------------
// Move line assertion macros
// Concurrent check macros for the move line unit; empty when NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef MOVE_LINE_AIM_AND_ADVANCE_TOP_ASSERT_SVH
`define MOVE_LINE_AIM_AND_ADVANCE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define MLAA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define MLAA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MLAA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MLAA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/mlaa_pkg.sv
// ----------------------------------------------------------------------------
// Move line package
// Widths, angle constants, arctangent table and shared control types.
// ----------------------------------------------------------------------------
package mlaa_pkg;

    localparam int TILE_BITS    = 8;
    localparam int TILE_IN_W    = 8;
    localparam int DIFF_W       = 9;
    localparam int STEP_W       = 10;
    localparam int HEAD_W       = 9;
    localparam int POS_W        = 32;
    localparam int TILE_OUT_W   = 24;
    localparam int SPEED_W      = 16;
    localparam int PROD_W       = STEP_W + SPEED_W + 1;

    // Angle accumulator: 2^24 units per full circle
    localparam int ANG_W        = 26;
    localparam int CORDIC_STEPS = 20;
    localparam int CIDX_W       = 5;
    localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(4194304);
    localparam logic signed [ANG_W-1:0] ANG_HALF    = ANG_W'(8388608);

    typedef struct packed {
        logic                     start;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } aim_req_t;

    typedef struct packed {
        logic                    busy;
        logic signed [ANG_W-1:0] angle;
    } cordic_res_t;

    typedef struct packed {
        logic                     busy;
        logic signed [STEP_W-1:0] step_x;
        logic signed [STEP_W-1:0] step_y;
    } ustep_res_t;

    // Arctangent of 2^-i in accumulator units, rounded
    function automatic logic signed [ANG_W-1:0] atan_unit(input logic [CIDX_W-1:0] idx);
        logic signed [ANG_W-1:0] val;
        unique case (idx)
            5'd0:    val = ANG_W'(2097152);
            5'd1:    val = ANG_W'(1238021);
            5'd2:    val = ANG_W'(654136);
            5'd3:    val = ANG_W'(332050);
            5'd4:    val = ANG_W'(166669);
            5'd5:    val = ANG_W'(83416);
            5'd6:    val = ANG_W'(41718);
            5'd7:    val = ANG_W'(20860);
            5'd8:    val = ANG_W'(10430);
            5'd9:    val = ANG_W'(5215);
            5'd10:   val = ANG_W'(2608);
            5'd11:   val = ANG_W'(1304);
            5'd12:   val = ANG_W'(652);
            5'd13:   val = ANG_W'(326);
            5'd14:   val = ANG_W'(163);
            5'd15:   val = ANG_W'(81);
            5'd16:   val = ANG_W'(41);
            5'd17:   val = ANG_W'(20);
            5'd18:   val = ANG_W'(10);
            5'd19:   val = ANG_W'(5);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

FILE: hdl/move_line_aim_and_advance_top.sv
// ----------------------------------------------------------------------------
// Move line aim and advance unit
// Holds one move line (24.8 position, per-step velocity); aims it from a
// start tile at a target tile, or advances it by velocity times speed.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                      Payload
//  -------   ---  -----------------------------  -------------------------------
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: kind; tdata: tiles, speed
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: heading .. tile_y
//  cfg       in   cfg_wr_en                      cfg_wr_data: heading_round_mode
//
//  Aim: the result waits on the step search unit (two axes of ten candidate
//  bits plus a finish step each); the angle CORDIC (20 iterations) runs
//  alongside. Equal tiles skip both units and go straight to the done state.
//  Advance: one shared 10x17 multiplier used for x then y.
//  One item at a time; s_axis_tready is high only while the sequencer is idle.
//  A result waits in the output register; a finished item holds in its final
//  state while that register is still full. Reset clears position, velocity
//  and the round mode to zero.
//
`include "move_line_aim_and_advance_top_assert.svh"

module move_line_aim_and_advance_top
    import mlaa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,     // [0] heading_round_mode

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,    // [7:0] start_tile_x, [15:8] start_tile_y,
                                          // [23:16] target_tile_x, [31:24] target_tile_y,
                                          // [47:32] speed
    input  logic [0:0]   s_axis_tuser,    // [0] kind (0 aim, 1 advance)

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata     // [8:0] heading, [18:9] step_x, [28:19] step_y,
                                          // [60:29] position_x, [92:61] position_y,
                                          // [116:93] tile_x, [140:117] tile_y, rest zero
);

    localparam int OUT_W = 144;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_AIM   = 3'd1;
    localparam logic [2:0] ST_ADV_X = 3'd2;
    localparam logic [2:0] ST_ADV_Y = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // Sequencer and line state
    logic [2:0]               state_reg,   state_next;
    logic [POS_W-1:0]         pos_x_reg,   pos_x_next;
    logic [POS_W-1:0]         pos_y_reg,   pos_y_next;
    logic signed [STEP_W-1:0] vel_x_reg,   vel_x_next;
    logic signed [STEP_W-1:0] vel_y_reg,   vel_y_next;
    logic signed [HEAD_W-1:0] heading_reg, heading_next;
    logic                     round_mode_reg;
    logic                     m_valid_reg, m_valid_next;

    // Payload holding registers
    logic [SPEED_W-1:0]       speed_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [OUT_W-1:0]         m_data_reg;

    // Input fields
    logic                     in_kind;
    logic [TILE_IN_W-1:0]     in_sx;
    logic [TILE_IN_W-1:0]     in_sy;
    logic [TILE_IN_W-1:0]     in_tx;
    logic [TILE_IN_W-1:0]     in_ty;
    logic [SPEED_W-1:0]       in_speed;
    logic                     in_accept;
    logic                     same_tile;

    aim_req_t                 unit_req;
    cordic_res_t              cordic_res;
    ustep_res_t               ustep_res;

    // Shared multiplier and output formatting
    logic signed [STEP_W-1:0]  mul_a;
    logic signed [SPEED_W:0]   mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [POS_W-1:0]          prod_ext;
    logic [ANG_W-1:0]          ang_mag;
    logic [ANG_W-1:0]          ang_rnd;
    logic [HEAD_W-1:0]         head_mag;
    logic signed [HEAD_W-1:0]  head_val;
    logic signed [POS_W-1:0]   tile_x_full;
    logic signed [POS_W-1:0]   tile_y_full;
    logic                      out_free;

    assign in_kind   = s_axis_tuser[0];
    assign in_sx     = s_axis_tdata[7:0];
    assign in_sy     = s_axis_tdata[15:8];
    assign in_tx     = s_axis_tdata[23:16];
    assign in_ty     = s_axis_tdata[31:24];
    assign in_speed  = s_axis_tdata[47:32];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign same_tile     = (in_sx == in_tx) && (in_sy == in_ty);
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Launch both units on an aim with a real direction
    assign unit_req.start = in_accept && !in_kind && !same_tile;
    assign unit_req.dx    = {1'b0, in_tx} - {1'b0, in_sx};
    assign unit_req.dy    = {1'b0, in_ty} - {1'b0, in_sy};

    mlaa_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (unit_req),
        .res   (cordic_res)
    );

    mlaa_ustep u_ustep
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (unit_req),
        .res   (ustep_res)
    );

    // One multiplier: x velocity at accept, y velocity in the cycle after
    assign mul_a    = (state_reg == ST_IDLE) ? vel_x_reg : vel_y_reg;
    assign mul_b    = (state_reg == ST_IDLE) ? signed'({1'b0, in_speed})
                                             : signed'({1'b0, speed_reg});
    assign mul_p    = mul_a * mul_b;
    assign prod_ext = {{(POS_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Heading: magnitude scaled down by 2^16, truncated or rounded, sign restored
    always_comb
    begin
        ang_mag  = cordic_res.angle[ANG_W-1] ? -cordic_res.angle : cordic_res.angle;
        ang_rnd  = round_mode_reg ? (ang_mag + ANG_W'(32768)) : ang_mag;
        head_mag = ang_rnd[16 +: HEAD_W];
        head_val = cordic_res.angle[ANG_W-1] ? -signed'(head_mag) : signed'(head_mag);
    end

    always_comb
    begin
        state_next   = state_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        vel_x_next   = vel_x_reg;
        vel_y_next   = vel_y_reg;
        heading_next = heading_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (!in_kind)
                    begin
                        // Aim: drop the line onto the centre of the start tile
                        pos_x_next = (POS_W'(in_sx) << TILE_BITS) + (POS_W'(1) << (TILE_BITS - 1));
                        pos_y_next = (POS_W'(in_sy) << TILE_BITS) + (POS_W'(1) << (TILE_BITS - 1));
                        if (same_tile)
                        begin
                            vel_x_next   = STEP_W'(256);
                            vel_y_next   = '0;
                            heading_next = '0;
                            state_next   = ST_DONE;
                        end
                        else
                            state_next = ST_AIM;
                    end
                    else
                    begin
                        heading_next = '0;
                        state_next   = ST_ADV_X;
                    end
                end
            end
            ST_AIM:
            begin
                // Hold until both units have settled
                if (!cordic_res.busy && !ustep_res.busy)
                begin
                    vel_x_next   = ustep_res.step_x;
                    vel_y_next   = ustep_res.step_y;
                    heading_next = head_val;
                    state_next   = ST_DONE;
                end
            end
            ST_ADV_X:
            begin
                pos_x_next = pos_x_reg + prod_ext;
                state_next = ST_ADV_Y;
            end
            ST_ADV_Y:
            begin
                pos_y_next = pos_y_reg + prod_ext;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Load the output register once it is free
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            vel_x_reg      <= '0;
            vel_y_reg      <= '0;
            heading_reg    <= '0;
            round_mode_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            vel_x_reg   <= vel_x_next;
            vel_y_reg   <= vel_y_next;
            heading_reg <= heading_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en)
                round_mode_reg <= cfg_wr_data;
        end
    end

    assign tile_x_full = signed'(pos_x_reg) >>> TILE_BITS;
    assign tile_y_full = signed'(pos_y_reg) >>> TILE_BITS;

    always_ff @(posedge clk)
    begin
        if (in_accept)
            speed_reg <= in_speed;
        prod_reg <= mul_p;
        if (state_reg == ST_DONE && out_free)
        begin
            m_data_reg <= {3'b0,
                           tile_y_full[TILE_OUT_W-1:0],
                           tile_x_full[TILE_OUT_W-1:0],
                           pos_y_reg,
                           pos_x_reg,
                           vel_y_reg,
                           vel_x_reg,
                           heading_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Checks
    `MLAA_ASSERT_IMP(a_units_quiet_when_open, clk, rst_n, s_axis_tready, !cordic_res.busy && !ustep_res.busy, "unit busy while input is open")
    `MLAA_ASSERT_NXT(a_search_runs_after_aim, clk, rst_n, unit_req.start, ustep_res.busy && (state_reg == ST_AIM), "aim launch did not start the step search")
    `MLAA_ASSERT_IMP(a_step_range, clk, rst_n, 1'b1, (vel_x_reg >= -10'sd256) && (vel_x_reg <= 10'sd256) && (vel_y_reg >= -10'sd256) && (vel_y_reg <= 10'sd256), "velocity outside unit range")
    `MLAA_ASSERT_IMP(a_heading_range, clk, rst_n, 1'b1, (heading_reg >= -9'sd128) && (heading_reg <= 9'sd128), "heading outside half circle")

endmodule

FILE: hdl/mlaa_cordic.sv
// ----------------------------------------------------------------------------
// Move line CORDIC angle unit
// Vectoring CORDIC, one shift-add micro-rotation per cycle, 20 iterations.
// ----------------------------------------------------------------------------
module mlaa_cordic
    import mlaa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  aim_req_t    req,
    output cordic_res_t res
);

    localparam int XY_W = 28;
    localparam logic CD_IDLE = 1'b0;
    localparam logic CD_RUN  = 1'b1;

    logic                    state_reg;
    logic [CIDX_W-1:0]       iter_reg;
    logic signed [XY_W-1:0]  x_reg;
    logic signed [XY_W-1:0]  y_reg;
    logic signed [ANG_W-1:0] z_reg;

    logic signed [XY_W-1:0]  x_in;
    logic signed [XY_W-1:0]  y_in;
    logic signed [XY_W-1:0]  x_sh;
    logic signed [XY_W-1:0]  y_sh;
    logic signed [ANG_W-1:0] atan_val;

    assign x_in     = {{(XY_W-DIFF_W-16){req.dx[DIFF_W-1]}}, req.dx, 16'b0};
    assign y_in     = {{(XY_W-DIFF_W-16){req.dy[DIFF_W-1]}}, req.dy, 16'b0};
    assign x_sh     = x_reg >>> iter_reg;
    assign y_sh     = y_reg >>> iter_reg;
    assign atan_val = atan_unit(iter_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CD_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                CD_IDLE:
                begin
                    iter_reg <= '0;
                    if (req.start && req.dx != '0 && req.dy != '0)
                        state_reg <= CD_RUN;
                end
                CD_RUN:
                begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == CIDX_W'(CORDIC_STEPS - 1))
                        state_reg <= CD_IDLE;
                end
                default: state_reg <= CD_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == CD_IDLE)
        begin
            if (req.start)
            begin
                // Axis directions resolve without iterating
                priority if (req.dy == '0)
                    z_reg <= (req.dx > 0) ? '0 : ANG_HALF;
                else if (req.dx == '0)
                    z_reg <= (req.dy > 0) ? ANG_QUARTER : -ANG_QUARTER;
                else if (req.dx < 0)
                begin
                    // Pre-rotate by a quarter turn into the right half plane
                    if (req.dy >= 0)
                    begin
                        x_reg <= y_in;
                        y_reg <= -x_in;
                        z_reg <= ANG_QUARTER;
                    end
                    else
                    begin
                        x_reg <= -y_in;
                        y_reg <= x_in;
                        z_reg <= -ANG_QUARTER;
                    end
                end
                else
                begin
                    x_reg <= x_in;
                    y_reg <= y_in;
                    z_reg <= '0;
                end
            end
        end
        else
        begin
            if (!y_reg[XY_W-1])
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_val;
            end
            else
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_val;
            end
        end
    end

    // Clamp to half a circle either way
    always_comb
    begin
        res.busy = (state_reg == CD_RUN);
        priority if (z_reg > ANG_HALF)
            res.angle = ANG_HALF;
        else if (z_reg < -ANG_HALF)
            res.angle = -ANG_HALF;
        else
            res.angle = z_reg;
    end

endmodule

FILE: hdl/mlaa_ustep.sv
// ----------------------------------------------------------------------------
// Move line unit step search
// Finds round(256*d/r) per axis by a bit-serial search on k^2*s <= 2^18*d^2,
// one candidate bit per cycle, squares kept up to date by shift-add only.
// ----------------------------------------------------------------------------
module mlaa_ustep
    import mlaa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  aim_req_t   req,
    output ustep_res_t res
);

    localparam int K_W  = 10;
    localparam int SQ_W = 16;
    localparam int S_W  = 17;
    localparam int KS_W = 27;
    localparam int CW   = 39;

    localparam logic [1:0] US_IDLE = 2'd0;
    localparam logic [1:0] US_RUN  = 2'd1;
    localparam logic [1:0] US_FIN  = 2'd2;

    logic [1:0]             state_reg;
    logic                   axis_reg;
    logic [3:0]             bit_reg;
    logic [K_W-1:0]         k_reg;
    logic [KS_W-1:0]        ks_reg;
    logic [CW-1:0]          kks_reg;
    logic [SQ_W-1:0]        sq_x_reg;
    logic [SQ_W-1:0]        sq_y_reg;
    logic                   neg_x_reg;
    logic                   neg_y_reg;
    logic signed [STEP_W-1:0] step_x_reg;
    logic signed [STEP_W-1:0] step_y_reg;

    logic [TILE_IN_W-1:0]   abs_x;
    logic [TILE_IN_W-1:0]   abs_y;
    logic [DIFF_W-1:0]      neg_dx;
    logic [DIFF_W-1:0]      neg_dy;
    logic [S_W-1:0]         sum_sq;
    logic [SQ_W-1:0]        sq_cur;
    logic                   neg_cur;
    logic [CW-1:0]          target;
    logic [4:0]             sh_ks;
    logic [4:0]             sh_s;
    logic [CW-1:0]          cand;
    logic                   take;
    logic [K_W-1:0]         bit_mask;
    logic [KS_W-1:0]        ks_add;
    logic signed [K_W:0]    k_ext;
    logic signed [K_W:0]    fw;
    logic signed [K_W:0]    fw_inc;

    always_comb
    begin
        neg_dx   = -req.dx;
        neg_dy   = -req.dy;
        abs_x    = req.dx[DIFF_W-1] ? neg_dx[TILE_IN_W-1:0] : req.dx[TILE_IN_W-1:0];
        abs_y    = req.dy[DIFF_W-1] ? neg_dy[TILE_IN_W-1:0] : req.dy[TILE_IN_W-1:0];
        sum_sq   = S_W'(sq_x_reg) + S_W'(sq_y_reg);
        sq_cur   = axis_reg ? sq_y_reg : sq_x_reg;
        neg_cur  = axis_reg ? neg_y_reg : neg_x_reg;
        target   = {5'b0, sq_cur, 18'b0};
        sh_ks    = {1'b0, bit_reg} + 5'd1;
        sh_s     = {bit_reg, 1'b0};
        // (k + 2^b)^2 * s = k^2 s + 2^(b+1) k s + 2^(2b) s
        cand     = kks_reg + ({12'b0, ks_reg} << sh_ks) + ({22'b0, sum_sq} << sh_s);
        take     = (cand <= target);
        bit_mask = K_W'(1) << bit_reg;
        ks_add   = ks_reg + ({10'b0, sum_sq} << bit_reg);
        // Negative axis: floor of the negated ratio, then round half up
        k_ext    = {1'b0, k_reg};
        if (!neg_cur)
            fw = k_ext;
        else if (kks_reg == target)
            fw = -k_ext;
        else
            fw = -k_ext - 11'sd1;
        fw_inc   = fw + 11'sd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= US_IDLE;
            axis_reg  <= 1'b0;
            bit_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                US_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg <= US_RUN;
                        axis_reg  <= 1'b0;
                        bit_reg   <= 4'd9;
                    end
                end
                US_RUN:
                begin
                    if (bit_reg == '0)
                        state_reg <= US_FIN;
                    else
                        bit_reg <= bit_reg - 1'b1;
                end
                US_FIN:
                begin
                    if (!axis_reg)
                    begin
                        axis_reg  <= 1'b1;
                        bit_reg   <= 4'd9;
                        state_reg <= US_RUN;
                    end
                    else
                        state_reg <= US_IDLE;
                end
                default: state_reg <= US_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            US_IDLE:
            begin
                if (req.start)
                begin
                    sq_x_reg  <= abs_x * abs_x;
                    sq_y_reg  <= abs_y * abs_y;
                    neg_x_reg <= req.dx[DIFF_W-1];
                    neg_y_reg <= req.dy[DIFF_W-1];
                    k_reg     <= '0;
                    ks_reg    <= '0;
                    kks_reg   <= '0;
                end
            end
            US_RUN:
            begin
                if (take)
                begin
                    k_reg   <= k_reg | bit_mask;
                    ks_reg  <= ks_add;
                    kks_reg <= cand;
                end
            end
            US_FIN:
            begin
                if (!axis_reg)
                    step_x_reg <= fw_inc[K_W:1];
                else
                    step_y_reg <= fw_inc[K_W:1];
                k_reg   <= '0;
                ks_reg  <= '0;
                kks_reg <= '0;
            end
            default:
            begin
                k_reg <= '0;
            end
        endcase
    end

    assign res.busy   = (state_reg != US_IDLE);
    assign res.step_x = step_x_reg;
    assign res.step_y = step_y_reg;

endmodule
